### hdl/pedsd_pkg.sv
// ----------------------------------------------------------------------------
// pedsd_pkg: shared types and constants for the pad edge and stick deadzone
// Widths of the stream fields, controller states, datapath operation codes
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pedsd_pkg;

  // field widths
  localparam int BTN_W       = 14;
  localparam int STICK_W     = 8;
  localparam int NORM_W      = 16;
  localparam int MAG_W       = 15;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 96;

  // arithmetic widths
  localparam int FRAC_BITS = 14;          // Q1.14
  localparam int SQ_W      = 16;          // squares, squared sum, divisor
  localparam int NUM_W     = 44;          // widest dividend or radicand
  localparam int QUO_W     = 29;          // widest quotient
  localparam int ROOT_W    = 22;          // widest root
  localparam int REM_W     = 24;          // root remainder
  localparam int CNT_W     = 5;

  // iteration counts of the shared units
  localparam int WIDE_STEPS       = 29;   // clamp divide, quotient up to 2^28
  localparam int NARROW_STEPS     = 15;   // divides by max radius
  localparam int ROOT_BIG_STEPS   = 22;   // root of the shifted squared sum
  localparam int ROOT_SMALL_STEPS = 15;   // root of a clamp quotient

  localparam logic [MAG_W-1:0] Q_ONE = MAG_W'(1 << FRAC_BITS);

  localparam logic [CFG_W-1:0] DEAD_RADIUS_RST = 8'd8;
  localparam logic [CFG_W-1:0] MAX_RADIUS_RST  = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEAD_RADIUS = 1'b0,
    CFG_MAX_RADIUS  = 1'b1
  } cfg_idx_t;

  // one operation of the shared divide / root unit
  typedef enum logic [2:0] {
    OP_CX_DIV,    // x^2 << 28 / s
    OP_CX_SQRT,   // root of that quotient
    OP_CY_DIV,
    OP_CY_SQRT,
    OP_IX_DIV,    // x << 14 / max radius
    OP_IY_DIV,
    OP_IM_SQRT,   // root of s << 28
    OP_IM_DIV     // that root / max radius
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_DISPATCH,
    ST_LOAD,
    ST_STEP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic square;
    logic sum;
    logic dispatch;
    logic load;
    logic step;
    logic last;
    logic emit;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic dead;
    logic clamp;
    logic out_busy;
  } status_t;

  function automatic logic is_root_op(op_t op);
    return (op == OP_CX_SQRT) || (op == OP_CY_SQRT) || (op == OP_IM_SQRT);
  endfunction

  function automatic logic is_wide_div(op_t op);
    return (op == OP_CX_DIV) || (op == OP_CY_DIV);
  endfunction

  function automatic logic [CNT_W-1:0] op_steps(op_t op);
    logic [CNT_W-1:0] n;
    case (op)
      OP_CX_DIV, OP_CY_DIV:   n = CNT_W'(WIDE_STEPS);
      OP_CX_SQRT, OP_CY_SQRT: n = CNT_W'(ROOT_SMALL_STEPS);
      OP_IM_SQRT:             n = CNT_W'(ROOT_BIG_STEPS);
      default:                n = CNT_W'(NARROW_STEPS);
    endcase
    return n;
  endfunction

endpackage

### hdl/pedsd_ctrl.sv
// ----------------------------------------------------------------------------
// pedsd_ctrl: sequencer for the pad edge and stick deadzone
// Takes one poll, walks the datapath through squaring, classification and
// the chain of divide and root operations, then hands the result over.
// ----------------------------------------------------------------------------
module pedsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  pedsd_pkg::status_t status,
  output pedsd_pkg::cmd_t   cmd
);
  import pedsd_pkg::*;

  state_t           state, state_next;
  op_t              op, op_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // state, operation and step count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_CX_DIV;
      cnt   <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    op_next    = op;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.op     = op;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        cmd.dispatch = 1'b1;
        if (status.dead) begin
          state_next = ST_EMIT;
        end else begin
          op_next    = status.clamp ? OP_CX_DIV : OP_IX_DIV;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        cnt_next   = op_steps(op) - CNT_W'(1);
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (cnt == '0) begin
          cmd.last   = 1'b1;
          state_next = ST_LOAD;
          // chain of operations for the clamped and the inner case
          case (op)
            OP_CX_DIV:  op_next = OP_CX_SQRT;
            OP_CX_SQRT: op_next = OP_CY_DIV;
            OP_CY_DIV:  op_next = OP_CY_SQRT;
            OP_IX_DIV:  op_next = OP_IY_DIV;
            OP_IY_DIV:  op_next = OP_IM_SQRT;
            OP_IM_SQRT: op_next = OP_IM_DIV;
            default:    state_next = ST_EMIT;
          endcase
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/pedsd_dp.sv
// ----------------------------------------------------------------------------
// pedsd_dp: datapath of the pad edge and stick deadzone
// Button edge masks, stick squares and classification, a shared restoring
// divider and bit-pair square root unit, and the output register.
// ----------------------------------------------------------------------------
module pedsd_dp #(
  parameter int BUTTONS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pedsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pedsd_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [pedsd_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  pedsd_pkg::cmd_t                    cmd,
  output pedsd_pkg::status_t                 status,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pedsd_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import pedsd_pkg::*;

  localparam logic [BTN_W-1:0] BtnMask =
    (BUTTONS >= BTN_W) ? {BTN_W{1'b1}} : BTN_W'((64'd1 << BUTTONS) - 64'd1);
  localparam int PadW = OUT_TDATA_W - 3 * BTN_W - 2 * NORM_W - MAG_W;

  // configuration
  logic [CFG_W-1:0] dead_radius, max_radius, m_eff;

  // poll registers
  logic [BTN_W-1:0]   prev_held, held, pressed, released, btn_now;
  logic               sx, sy;
  logic [STICK_W-1:0] ax, ay, x_in, y_in;
  logic [SQ_W-1:0]    ax2, ay2, d2, m2, s;
  logic [MAG_W-1:0]   qx, qy, qm;

  // divider
  logic [NUM_W-1:0] div_n, div_num, div_hi;
  logic [SQ_W-1:0]  div_r, div_d, div_den, div_r_next;
  logic [SQ_W:0]    div_t;
  logic             div_ge;
  logic [QUO_W-1:0] div_q, div_q_next;

  // square root
  logic [NUM_W-1:0]  sq_n, sq_rad;
  logic [REM_W-1:0]  sq_r, sq_r_next;
  logic [REM_W+1:0]  sq_t, sq_trial;
  logic              sq_ge;
  logic [ROOT_W-1:0] sq_root, sq_root_next;

  logic [NORM_W-1:0] nx, ny;

  // input unpacking
  assign btn_now = s_tdata[BTN_W-1:0] & BtnMask;
  assign x_in    = s_tdata[BTN_W +: STICK_W];
  assign y_in    = s_tdata[BTN_W + STICK_W +: STICK_W];
  assign m_eff   = (max_radius == '0) ? CFG_W'(1) : max_radius;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_radius <= DEAD_RADIUS_RST;
      max_radius  <= MAX_RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEAD_RADIUS: dead_radius <= cfg_wdata;
        CFG_MAX_RADIUS:  max_radius  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // previous held buttons
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_held <= '0;
    end else if (cmd.accept) begin
      prev_held <= btn_now;
    end
  end

  // classification flags
  assign status.dead     = s < d2;
  assign status.clamp    = s > m2;
  assign status.out_busy = m_tvalid && !m_tready;

  // divider operand selection
  always_comb begin
    case (cmd.op)
      OP_CX_DIV: begin
        div_num = NUM_W'(ax2) << (2 * FRAC_BITS);
        div_den = s;
      end
      OP_CY_DIV: begin
        div_num = NUM_W'(ay2) << (2 * FRAC_BITS);
        div_den = s;
      end
      OP_IX_DIV: begin
        div_num = NUM_W'(ax) << FRAC_BITS;
        div_den = SQ_W'(m_eff);
      end
      OP_IY_DIV: begin
        div_num = NUM_W'(ay) << FRAC_BITS;
        div_den = SQ_W'(m_eff);
      end
      OP_IM_DIV: begin
        div_num = NUM_W'(sq_root);
        div_den = SQ_W'(m_eff);
      end
      default: begin
        div_num = '0;
        div_den = s;
      end
    endcase
  end

  // the quotient fits the step count, so the bits above it start the remainder
  assign div_hi = is_wide_div(cmd.op) ? (div_num >> WIDE_STEPS) : (div_num >> NARROW_STEPS);

  // one quotient bit per step
  assign div_t      = {div_r, div_n[NUM_W-1]};
  assign div_ge     = div_t >= {1'b0, div_d};
  assign div_r_next = div_ge ? SQ_W'(div_t - {1'b0, div_d}) : div_t[SQ_W-1:0];
  assign div_q_next = {div_q[QUO_W-2:0], div_ge};

  // radicand alignment, consumed two bits per step from the top
  assign sq_rad = (cmd.op == OP_IM_SQRT) ? (NUM_W'(s) << (2 * FRAC_BITS))
                                         : (NUM_W'(div_q) << (NUM_W - 2 * ROOT_SMALL_STEPS));

  // one root bit per step
  assign sq_t         = {sq_r, sq_n[NUM_W-1 -: 2]};
  assign sq_trial     = {2'b00, sq_root, 2'b01};
  assign sq_ge        = sq_t >= sq_trial;
  assign sq_r_next    = sq_ge ? REM_W'(sq_t - sq_trial) : sq_t[REM_W-1:0];
  assign sq_root_next = {sq_root[ROOT_W-2:0], sq_ge};

  // poll and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      held     <= btn_now;
      pressed  <= btn_now & ~prev_held;
      released <= prev_held & ~btn_now;
      sx       <= x_in[STICK_W-1];
      sy       <= y_in[STICK_W-1];
      ax       <= x_in[STICK_W-1] ? STICK_W'(-x_in) : x_in;
      ay       <= y_in[STICK_W-1] ? STICK_W'(-y_in) : y_in;
    end
    if (cmd.square) begin
      ax2 <= SQ_W'(ax) * SQ_W'(ax);
      ay2 <= SQ_W'(ay) * SQ_W'(ay);
      d2  <= SQ_W'(dead_radius) * SQ_W'(dead_radius);
      m2  <= SQ_W'(m_eff) * SQ_W'(m_eff);
    end
    if (cmd.sum) begin
      s <= ax2 + ay2;
    end
    if (cmd.dispatch) begin
      qx <= '0;
      qy <= '0;
      qm <= (status.clamp && !status.dead) ? Q_ONE : '0;
    end
    // load or step the shared unit
    if (cmd.load) begin
      if (is_root_op(cmd.op)) begin
        sq_n    <= sq_rad;
        sq_r    <= '0;
        sq_root <= '0;
      end else begin
        div_r <= div_hi[SQ_W-1:0];
        div_n <= is_wide_div(cmd.op) ? (div_num << (NUM_W - WIDE_STEPS))
                                     : (div_num << (NUM_W - NARROW_STEPS));
        div_d <= div_den;
        div_q <= '0;
      end
    end
    if (cmd.step) begin
      if (is_root_op(cmd.op)) begin
        sq_n    <= sq_n << 2;
        sq_r    <= sq_r_next;
        sq_root <= sq_root_next;
      end else begin
        div_n <= div_n << 1;
        div_r <= div_r_next;
        div_q <= div_q_next;
      end
    end
    // capture the finished operation
    if (cmd.step && cmd.last) begin
      case (cmd.op)
        OP_CX_SQRT: qx <= sq_root_next[MAG_W-1:0];
        OP_CY_SQRT: qy <= sq_root_next[MAG_W-1:0];
        OP_IX_DIV:  qx <= div_q_next[MAG_W-1:0];
        OP_IY_DIV:  qy <= div_q_next[MAG_W-1:0];
        OP_IM_DIV:  qm <= div_q_next[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // signed outputs
  assign nx = sx ? (NORM_W'(0) - NORM_W'(qx)) : NORM_W'(qx);
  assign ny = sy ? (NORM_W'(0) - NORM_W'(qy)) : NORM_W'(qy);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {{PadW{1'b0}}, qm, ny, nx, released, pressed, held};
    end
  end

endmodule

### hdl/pad_edge_and_stick_deadzone.sv
// ----------------------------------------------------------------------------
// pad_edge_and_stick_deadzone: controller poll conditioning
// Button held / pressed / released masks and a radial stick deadzone with
// clamping and Q1.14 normalization.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one transfer per controller poll (buttons, stick x, y).
//   m_* stream: one transfer per poll with the three button masks and the
//   normalized x, y and magnitude.
//   cfg_*: write dead_radius (index 0) and max_radius (index 1) while idle.
// Timing: the poll is squared, summed and classified, then a shared unit
//   retires one quotient or root bit per cycle, after a load step for each
//   operation. A poll in the dead zone skips the divide and root chain; a
//   new poll is taken only once the result of the last one has gone into
//   the output register.
// Reset: registers return to dead_radius 8, max_radius 64, no buttons held
//   previously, and no result pending.
// Stall: the result sits in an output register; the next poll is accepted
//   and worked on while it waits, and only the hand-over to the output
//   register waits for the receiver.
// ----------------------------------------------------------------------------
module pad_edge_and_stick_deadzone #(
  parameter int BUTTONS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  // config write
  input  logic                               cfg_we,
  input  logic [pedsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pedsd_pkg::CFG_W-1:0]        cfg_wdata,
  // poll input
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // button_levels, stick_x, stick_y, zero pad
  input  logic [pedsd_pkg::IN_TDATA_W-1:0]   s_tdata,
  // result output
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // held_mask, pressed_mask, released_mask, norm_x, norm_y, norm_magnitude,
  // zero pad
  output logic [pedsd_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import pedsd_pkg::*;

  cmd_t    cmd;
  status_t status;

  pedsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pedsd_dp #(
    .BUTTONS (BUTTONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

### hdl/pedsd_checker.sv
// ----------------------------------------------------------------------------
// pedsd_checker: port-level checks for the pad edge and stick deadzone
// Watches the stream ports for reset, stall and result consistency.
// ----------------------------------------------------------------------------
module pedsd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [pedsd_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import pedsd_pkg::*;

  logic [BTN_W-1:0]  held, pressed, released;
  logic [NORM_W-1:0] nx, ny;
  logic [MAG_W-1:0]  mag;

  assign held     = m_tdata[0 +: BTN_W];
  assign pressed  = m_tdata[BTN_W +: BTN_W];
  assign released = m_tdata[2 * BTN_W +: BTN_W];
  assign nx       = m_tdata[3 * BTN_W +: NORM_W];
  assign ny       = m_tdata[3 * BTN_W + NORM_W +: NORM_W];
  assign mag      = m_tdata[3 * BTN_W + 2 * NORM_W +: MAG_W];

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // one poll at a time
  a_one_poll: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second poll taken while one is in work");

  // edge masks agree with the held mask
  a_edges: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((pressed & released) == '0) && ((pressed & ~held) == '0)
                 && ((released & held) == '0))
    else $error("inconsistent button masks");

  // zero magnitude means a centered stick
  a_center: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (mag == '0) |-> (nx == '0) && (ny == '0))
    else $error("stick off center with zero magnitude");

endmodule

bind pad_edge_and_stick_deadzone pedsd_checker u_chk (.*);

### sim/tb_pad_edge_and_stick_deadzone.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pad_edge_and_stick_deadzone: self-checking bench for the poll conditioner
// Drives controller polls over the input stream and predicts the button
// masks and the Q1.14 stick result of each one with an integer model of the
// deadzone, clamp and normalization math. Every output transfer is compared
// field by field against the oldest prediction. Both sides stall at random,
// and the radii are swept across their extremes between bursts.
// ----------------------------------------------------------------------------
module tb_pad_edge_and_stick_deadzone;
  import pedsd_pkg::*;

  typedef struct {
    logic [BTN_W-1:0]  held;
    logic [BTN_W-1:0]  pressed;
    logic [BTN_W-1:0]  released;
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
    logic [MAG_W-1:0]  nm;
  } poll_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  cfg_idx_t               cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // shadow of the block's registers and button state
  logic [CFG_W-1:0] dead_r;
  logic [CFG_W-1:0] max_r;
  logic [BTN_W-1:0] held_prev;
  logic [BTN_W-1:0] last_btn;

  poll_result_t expected_polls[$];
  int           errors;
  bit           no_idle;
  int           hold_req;
  int           hold_left;
  string        field_name[6] = '{"held_mask", "pressed_mask", "released_mask",
                                  "norm_x", "norm_y", "norm_magnitude"};

  pad_edge_and_stick_deadzone #(.BUTTONS(14)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bitwise integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // expected masks and normalized stick for one poll at the current radii
  function automatic poll_result_t predict_poll(logic [BTN_W-1:0] btn,
                                                logic signed [STICK_W-1:0] x,
                                                logic signed [STICK_W-1:0] y);
    poll_result_t    r;
    longint          sx;
    longint          sy;
    longint unsigned ax, ay, s, m, dr, qx, qy, qm;
    sx = x;
    sy = y;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    s  = ax * ax + ay * ay;
    dr = dead_r;
    m  = (max_r == 0) ? 1 : max_r;
    r.held     = btn;
    r.pressed  = btn & ~held_prev;
    r.released = held_prev & ~btn;
    if (s < dr * dr) begin
      qx = 0;
      qy = 0;
      qm = 0;
    end else if (s > m * m) begin
      // scaled back onto the max circle
      qx = int_sqrt(((ax * ax) << 28) / s);
      qy = int_sqrt(((ay * ay) << 28) / s);
      qm = 16384;
    end else begin
      qx = (ax << FRAC_BITS) / m;
      qy = (ay << FRAC_BITS) / m;
      qm = int_sqrt(s << 28) / m;
    end
    r.nx = (sx < 0) ? NORM_W'(0 - qx) : NORM_W'(qx);
    r.ny = (sy < 0) ? NORM_W'(0 - qy) : NORM_W'(qy);
    r.nm = MAG_W'(qm);
    return r;
  endfunction

  // one poll transfer, with an occasional idle gap in front
  task automatic send_poll(logic [BTN_W-1:0] btn, logic signed [STICK_W-1:0] x,
                           logic signed [STICK_W-1:0] y);
    if (!no_idle && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, y, x, btn};
    do @(posedge clk); while (!s_tready);
    expected_polls.push_back(predict_poll(btn, x, y));
    held_prev = btn;
    last_btn  = btn;
  endtask

  // stop offering and let every pending result come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_polls.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // write both radii on back-to-back edges while idle
  task automatic set_radii(logic [CFG_W-1:0] dead, logic [CFG_W-1:0] maxv);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEAD_RADIUS;
    cfg_wdata <= dead;
    @(posedge clk);
    cfg_index <= CFG_MAX_RADIUS;
    cfg_wdata <= maxv;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    dead_r = dead;
    max_r  = maxv;
  endtask

  // random buttons and a stick aimed at the interesting regions
  task automatic send_random_poll();
    logic [BTN_W-1:0] btn;
    int               m, ax, ay, rem, x, y;
    case ($urandom_range(3))
      0: btn = BTN_W'($urandom);
      1: btn = last_btn;
      2: btn = last_btn ^ (BTN_W'(1) << $urandom_range(BTN_W - 1));
      default: btn = $urandom_range(1) ? '1 : '0;
    endcase
    m = (max_r == 0) ? 1 : max_r;
    case ($urandom_range(4))
      0, 1: begin
        x = $urandom_range(255) - 128;
        y = $urandom_range(255) - 128;
      end
      2: begin
        // around the dead circle
        x = $urandom_range(2 * dead_r + 4) - dead_r - 2;
        y = $urandom_range(2 * dead_r + 4) - dead_r - 2;
      end
      3: begin
        // on or next to the max circle
        ax  = $urandom_range((m > 128) ? 128 : m);
        rem = m * m - ax * ax;
        ay  = int'(int_sqrt(longint'(rem))) + $urandom_range(2) - 1;
        x   = $urandom_range(1) ? -ax : ax;
        y   = $urandom_range(1) ? -ay : ay;
      end
      default: begin
        x = $urandom_range(1) ? -128 : 127;
        y = $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? -128 : 127);
      end
    endcase
    if (x > 127) x = 127;
    if (x < -128) x = -128;
    if (y > 127) y = 127;
    if (y < -128) y = -128;
    send_poll(btn, STICK_W'(x), STICK_W'(y));
  endtask

  // reset radii: center, dead zone, both boundaries, clamp, button edges
  task automatic test_reset_radii();
    send_poll('0, 0, 0);
    send_poll('1, 127, 127);
    send_poll('0, -128, -128);
    send_poll(14'h2AAA, 5, 5);
    send_poll(14'h1555, 8, 0);
    send_poll(14'h1555, 0, -8);
    send_poll(14'h3F00, 64, 0);
    send_poll(14'h00FF, 65, 0);
    send_poll(14'h0001, -128, 0);
    send_poll(14'h2000, 0, 127);
    send_poll('1, 0, -128);
    send_poll('0, -45, 45);
    wait_drained();
  endtask

  // radius extremes and odd settings
  task automatic test_radius_extremes();
    set_radii(8'd0, 8'd1);
    send_poll(14'h0F0F, 0, 0);
    send_poll(14'h30F0, 1, 0);
    send_poll(14'h0F0F, -1, 1);
    wait_drained();
    set_radii(8'd0, 8'd181);
    send_poll('1, -128, -128);
    send_poll('0, 127, -127);
    wait_drained();
    set_radii(8'd181, 8'd181);
    send_poll(14'h1234, -128, -128);
    send_poll(14'h2345, 127, 127);
    wait_drained();
    // dead radius above max radius, dead test first
    set_radii(8'd100, 8'd30);
    send_poll(14'h0001, 60, 60);
    send_poll(14'h0002, 90, 90);
    wait_drained();
    // max radius zero acts as one
    set_radii(8'd0, 8'd0);
    send_poll(14'h3FFE, 1, 0);
    send_poll(14'h0003, -3, 4);
    wait_drained();
    set_radii(8'd255, 8'd255);
    send_poll(14'h0000, -128, -128);
    wait_drained();
    set_radii(8'd0, 8'd255);
    send_poll(14'h3FFF, -128, -128);
    wait_drained();
  endtask

  // random polls over a set of radii, one sender burst per setting
  task automatic test_random_sweep();
    int dead_list[8] = '{8, 0, 0, 181, 20, 100, -1, -1};
    int max_list[8]  = '{64, 1, 181, 181, 100, 30, -1, -1};
    for (int p = 0; p < 8; p++) begin
      set_radii(dead_list[p] < 0 ? CFG_W'($urandom_range(181)) : CFG_W'(dead_list[p]),
                max_list[p] < 0 ? CFG_W'($urandom_range(1, 181)) : CFG_W'(max_list[p]));
      no_idle = (p == 4);
      repeat (125) send_random_poll();
      no_idle = 1'b0;
      wait_drained();
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_backpressure();
    set_radii(8'd10, 8'd50);
    no_idle  = 1'b1;
    hold_req = 400;
    repeat (40) send_random_poll();
    no_idle = 1'b0;
    wait_drained();
  endtask

  // sender pauses until everything is out, then resumes
  task automatic test_drain_pause();
    set_radii(8'd12, 8'd90);
    repeat (20) send_random_poll();
    wait_drained();
    repeat (20) send_random_poll();
    wait_drained();
  endtask

  // output side: random ready, long hold on request, and the check
  always @(posedge clk) begin
    poll_result_t     want;
    logic [NORM_W-1:0] exp_f[6];
    logic [NORM_W-1:0] got_f[6];
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle || ($urandom_range(99) >= 24);
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_polls.size() == 0) begin
        $display("%0t: result transfer with no poll pending, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = expected_polls.pop_front();
        exp_f = '{want.held, want.pressed, want.released, want.nx, want.ny, want.nm};
        got_f = '{m_tdata[13:0], m_tdata[27:14], m_tdata[41:28], m_tdata[57:42],
                  m_tdata[73:58], m_tdata[88:74]};
        for (int f = 0; f < 6; f++) begin
          if (exp_f[f] !== got_f[f]) begin
            $display("%0t: %s expected %h actual %h", $time, field_name[f], exp_f[f],
                     got_f[f]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("pad_edge_and_stick_deadzone test failed");
    $finish;
  end

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_DEAD_RADIUS;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    errors    = 0;
    no_idle   = 1'b0;
    hold_req  = 0;
    hold_left = 0;
    dead_r    = DEAD_RADIUS_RST;
    max_r     = MAX_RADIUS_RST;
    held_prev = '0;
    last_btn  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_radii();
    test_radius_extremes();
    test_random_sweep();
    test_output_backpressure();
    test_drain_pause();

    wait_drained();
    if (errors == 0) begin
      $display("pad_edge_and_stick_deadzone test passed");
    end else begin
      $display("pad_edge_and_stick_deadzone test failed");
    end
    $finish;
  end

endmodule
